### src/prfl_pkg.sv
package prfl_pkg;

   // Fixed port widths
   localparam int PAGE_PORT_W  = 16;
   localparam int FRAME_PORT_W = 4;
   localparam int FAULT_W      = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam int CSR_FIU_W  = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 1'b1;

   localparam logic [CSR_FIU_W-1:0] FIU_RESET = 5'd16;

   // Replacement policy codes
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } prfl_state_type;

endpackage

### src/prfl_page_store.sv
module prfl_page_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] page_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write one frame entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= page_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/page_replacement_fifo_lru.sv
// Items are taken only while idle; the scan then compares one frame per cycle from frame
// zero, through the hit frame, or through all frames in use on a fault, reading the page
// store through its single read port; a write-back state then stores the update, and the
// result strobe is registered after it. busy holds new items off until write-back is over.
// Reset clears the policy to FIFO, the frame count to 16, all frames to empty, all ranks,
// the insertion pointer and the fault count; the receiver cannot stall results.
module page_replacement_fifo_lru #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [prfl_pkg::PAGE_PORT_W-1:0]     req_page_number,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic [prfl_pkg::FRAME_PORT_W-1:0]    rsp_frame_index,
   output logic                                 rsp_evicted_valid,
   output logic [prfl_pkg::PAGE_PORT_W-1:0]     rsp_evicted_page,
   output logic [prfl_pkg::FAULT_W-1:0]         rsp_fault_total,
   input  logic                                 csr_we,
   input  logic [prfl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [prfl_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import prfl_pkg::*;

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int NW    = (CNT_W > CSR_FIU_W) ? CNT_W : CSR_FIU_W;
   localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(FRAMES - 1);

   // Configuration registers
   logic                 policy_ff;
   logic [CSR_FIU_W-1:0] fiu_ff;

   // Control state
   prfl_state_type       state_ff, state_in;
   logic                 rsp_valid_ff;
   logic [IDX_W-1:0]     ptr_ff;
   logic [FAULT_W-1:0]   fault_ff;
   logic [FRAMES-1:0]    valid_ff;
   logic [IDX_W-1:0]     rank_ff [FRAMES];

   // Per-item working registers
   logic [PAGE_BITS-1:0] page_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic                 hit_ff;
   logic [IDX_W-1:0]     hit_idx_ff;
   logic [IDX_W-1:0]     hit_rank_ff;
   logic                 empty_found_ff;
   logic [IDX_W-1:0]     empty_idx_ff;
   logic [IDX_W-1:0]     vic_idx_ff;
   logic [IDX_W-1:0]     vic_rank_ff;
   logic [PAGE_BITS-1:0] vic_page_ff;

   // Result registers
   logic                    rsp_hit_ff;
   logic [FRAME_PORT_W-1:0] rsp_frame_ff;
   logic                    rsp_ev_valid_ff;
   logic [PAGE_PORT_W-1:0]  rsp_ev_page_ff;
   logic [FAULT_W-1:0]      rsp_fault_ff;

   // Combinational
   logic [NW-1:0]        fiu_ext;
   logic [CNT_W-1:0]     n_act;
   logic [IDX_W-1:0]     ptr_eff;
   logic [IDX_W-1:0]     ptr_next;
   logic                 accept;
   logic                 cmp_last;
   logic                 cur_valid;
   logic [IDX_W-1:0]     cur_rank;
   logic [PAGE_BITS-1:0] cur_page;
   logic                 match;
   logic                 take_vic;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     tgt;
   logic [IDX_W+3:0]     tgt_ext;
   logic                 ev_valid;
   logic [PAGE_BITS-1:0] ev_page;
   logic [FAULT_W-1:0]   fault_next;
   logic                 mem_we;
   logic [FRAMES-1:0]    in_use;
   logic [IDX_W-1:0]     rank_in [FRAMES];

   // Effective frame count: zero acts as one, clamp to FRAMES
   assign fiu_ext = NW'(fiu_ff);
   always_comb begin
      priority if (fiu_ext == '0) begin
         n_act = CNT_W'(1);
      end else if (fiu_ext > NW'(FRAMES)) begin
         n_act = CNT_W'(FRAMES);
      end else begin
         n_act = CNT_W'(fiu_ext);
      end
   end

   // FIFO insertion pointer, folded back to zero past the frame count
   assign ptr_eff  = (CNT_W'(ptr_ff) >= n_act) ? '0 : ptr_ff;
   assign ptr_next = ((CNT_W'(ptr_eff) + CNT_W'(1)) >= n_act) ? '0 : ptr_eff + IDX_W'(1);

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Compare stage: entry cmp_idx_ff arrives from the store this cycle
   assign cmp_last  = ((CNT_W'(cmp_idx_ff) + CNT_W'(1)) == n_act);
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign cur_rank  = rank_ff[cmp_idx_ff];
   assign match     = cur_valid && (cur_page == page_ff);
   assign take_vic  = (policy_ff == POLICY_FIFO) ? (cmp_idx_ff == ptr_eff)
                                                 : ((cmp_idx_ff == '0) || (cur_rank > vic_rank_ff));

   // Read address: first frame on accept, then the next frame while scanning
   always_comb begin
      rd_addr = cmp_idx_ff;
      if (state_ff == ST_IDLE) begin
         rd_addr = '0;
      end else if ((state_ff == ST_SCAN) && !cmp_last) begin
         rd_addr = cmp_idx_ff + IDX_W'(1);
      end
   end

   // Choose the frame that ends up holding the page
   always_comb begin
      priority if (hit_ff) begin
         tgt = hit_idx_ff;
      end else if (policy_ff == POLICY_FIFO) begin
         tgt = ptr_eff;
      end else if (empty_found_ff) begin
         tgt = empty_idx_ff;
      end else begin
         tgt = vic_idx_ff;
      end
   end

   assign tgt_ext    = {4'b0000, tgt};
   assign ev_valid   = !hit_ff && valid_ff[tgt];
   assign ev_page    = ev_valid ? vic_page_ff : '0;
   assign fault_next = (hit_ff || (fault_ff == FAULT_MAX)) ? fault_ff : fault_ff + FAULT_W'(1);
   assign mem_we     = (state_ff == ST_RESP) && !hit_ff;

   // Age ranks: touched frame goes to zero; other valid frames in use age by one (on a hit only the more recent ones)
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         in_use[i]  = (CNT_W'(i) < n_act);
         rank_in[i] = rank_ff[i];
         if (IDX_W'(i) == tgt) begin
            rank_in[i] = '0;
         end else if (valid_ff[i] && in_use[i] && (!hit_ff || (rank_ff[i] < hit_rank_ff)) &&
                      (rank_ff[i] != RANK_MAX)) begin
            rank_in[i] = rank_ff[i] + IDX_W'(1);
         end
      end
   end

   prfl_page_store #(
      .DEPTH  (FRAMES),
      .ADDR_W (IDX_W),
      .DATA_W (PAGE_BITS)
   ) u_page_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (tgt),
      .wr_data (page_ff),
      .rd_addr (rd_addr),
      .rd_data (cur_page)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match || cmp_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers and table bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         policy_ff    <= POLICY_FIFO;
         fiu_ff       <= FIU_RESET;
         ptr_ff       <= '0;
         fault_ff     <= '0;
         valid_ff     <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_RESP);
         if (csr_we) begin
            unique case (csr_index)
               CSR_POLICY_MODE:   policy_ff <= csr_wdata[0];
               CSR_FRAMES_IN_USE: fiu_ff    <= csr_wdata;
            endcase
         end
         if (state_ff == ST_RESP) begin
            fault_ff <= fault_next;
            if (!hit_ff) begin
               valid_ff[tgt] <= 1'b1;
               if (policy_ff == POLICY_FIFO) begin
                  ptr_ff <= ptr_next;
               end
            end
            if (policy_ff == POLICY_LRU) begin
               for (int i = 0; i < FRAMES; i++) begin
                  rank_ff[i] <= rank_in[i];
               end
            end
         end
      end
   end

   // Per-item scan trackers and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff        <= PAGE_BITS'(req_page_number);
         cmp_idx_ff     <= '0;
         hit_ff         <= 1'b0;
         empty_found_ff <= 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         if (match) begin
            hit_ff      <= 1'b1;
            hit_idx_ff  <= cmp_idx_ff;
            hit_rank_ff <= cur_rank;
         end
         if (!cur_valid && !empty_found_ff) begin
            empty_found_ff <= 1'b1;
            empty_idx_ff   <= cmp_idx_ff;
         end
         if (take_vic) begin
            vic_idx_ff  <= cmp_idx_ff;
            vic_rank_ff <= cur_rank;
            vic_page_ff <= cur_page;
         end
         if (!cmp_last) begin
            cmp_idx_ff <= cmp_idx_ff + IDX_W'(1);
         end
      end
      if (state_ff == ST_RESP) begin
         rsp_hit_ff      <= hit_ff;
         rsp_frame_ff    <= tgt_ext[FRAME_PORT_W-1:0];
         rsp_ev_valid_ff <= ev_valid;
         rsp_ev_page_ff  <= PAGE_PORT_W'(ev_page);
         rsp_fault_ff    <= fault_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = rsp_fault_ff;

   // A result follows only the write-back cycle
   a_rsp_after_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_RESP))
      else $error("result strobe without write-back cycle");

   // A hit never reports an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted_valid)
      else $error("hit reported an evicted page");

   // The scan never runs past the frames in use
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNT_W'(cmp_idx_ff) < n_act))
      else $error("scan index beyond frame count");

   // The fault count never decreases
   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (fault_ff >= $past(fault_ff)))
      else $error("fault count went backward");

endmodule
